### rtl/core/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is high
`define TFDT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// clocked assertion, checked on every edge
`define TFDT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/tfdt_pkg.sv
`default_nettype none
package tfdt_pkg;

   localparam int SCREEN_WIDTH_DEF = 320;
   localparam int SCREEN_HEIGHT_DEF = 240;
   localparam int TEX_WIDTH_DEF = 256;
   localparam int TEX_HEIGHT_DEF = 256;

   localparam int CFG_W = 48;
   localparam int CFG_IDX_W = 3;
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 64;

   localparam int A_W = 18;
   localparam int B_W = 40;
   localparam int PROD_W = A_W + B_W;
   localparam int ACC_W = 60;
   localparam int NUM_W = 60;
   localparam int DIV_W = 44;
   localparam int QUO_W = 16;
   localparam int STEP_W = 3;

   localparam logic signed [15:0] DEPTH_FAR = 16'sh7fff;

   typedef enum logic [2:0] {
      CFG_VA_POS, CFG_VB_POS, CFG_VC_POS, CFG_VA_UV, CFG_VB_UV, CFG_VC_UV
   } cfg_index_type;

   typedef enum logic [1:0] {
      REQ_LOAD, REQ_CLEAR, REQ_TEST, REQ_NONE
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_DONE, ST_OUT_BOX, ST_OUT_TRI, ST_OCCLUDED, ST_WRITTEN
   } status_type;

   typedef enum logic [3:0] {
      MUL_NONE, MUL_E0X_E1Y, MUL_E0Y_E1X_N, MUL_DX_E1Y, MUL_DY_E1X_N,
      MUL_E0X_DY, MUL_E0Y_DX_N, MUL_AZ_NU, MUL_BZ_NV, MUL_CZ_NW,
      MUL_AU_NU, MUL_BU_NV, MUL_CU_NW, MUL_AV_NU, MUL_BV_NV, MUL_CV_NW
   } mul_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD, ACC_LOAD, ACC_ADD
   } acc_op_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_TAKE, OP_LOAD_TEX, OP_CLEAR_DEPTH, OP_BOX, OP_CAP_DEN,
      OP_CAP_NV, OP_CAP_NW, OP_SIGN_FIX, OP_NU, OP_DIV_Z, OP_CAP_Z,
      OP_DEPTH_RD, OP_DEPTH_WR, OP_DIV_U, OP_CAP_U, OP_DIV_V, OP_CAP_V,
      OP_TEX_RD, OP_OUT
   } dp_op_type;

   typedef enum logic [4:0] {
      S_IDLE, S_DISPATCH, S_BOX, S_GEO, S_SIGNFIX, S_NU, S_TRI, S_ZMAC,
      S_ZDIV, S_DRD, S_DCMP, S_UMAC, S_UDIV, S_VMAC, S_VDIV, S_TRD, S_FIN
   } ctrl_state_type;

   typedef struct packed {
      dp_op_type   op;
      mul_sel_type mul;
      acc_op_type  acc;
      status_type  status;
   } cmd_type;

   typedef struct packed {
      logic [1:0] req;
      logic       box_out;
      logic       tri_out;
      logic       div_done;
      logic       occluded;
   } stat_type;

endpackage
`default_nettype wire

### rtl/core/triangle_fragment_depth_texture.sv
// Per-fragment stage of a triangle rasterizer with a depth store and a texel store. One beat
// in gives one beat out. A fragment test stops at the box test when outside the box, at the
// triangle test when outside the triangle, at the depth compare when occluded, and else at the
// texel read. A test's length is set by the single shared 18x40 multiplier, which
// builds the edge weights and the three weighted sums one product per cycle, and by the
// restoring divider, which makes one quotient bit a cycle for the depth, u and v quotients in
// turn. One item is in work at a time; the next beat is taken while a result still waits. The
// depth and texel stores are not cleared at reset: clear every depth entry and load every texel
// that a fragment may read.
`default_nettype none
module triangle_fragment_depth_texture #(
   parameter int SCREEN_WIDTH = tfdt_pkg::SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = tfdt_pkg::SCREEN_HEIGHT_DEF,
   parameter int TEX_WIDTH = tfdt_pkg::TEX_WIDTH_DEF,
   parameter int TEX_HEIGHT = tfdt_pkg::TEX_HEIGHT_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_wr_en,
   input  wire logic [tfdt_pkg::CFG_IDX_W-1:0]    csr_index,
   input  wire logic [tfdt_pkg::CFG_W-1:0]        csr_wdata,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // pixel_x, pixel_y, texel_u, texel_v, texel_color
   input  wire logic [tfdt_pkg::REQ_DATA_W-1:0]   req_tdata,
   // req_type
   input  wire logic [1:0]                        req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // out_x, out_y, out_color, out_depth
   output logic      [tfdt_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // status
   output logic      [2:0]                        rsp_tuser
);

   tfdt_pkg::cmd_type  cmd;
   tfdt_pkg::stat_type stat;

   tfdt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   tfdt_datapath #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT),
      .TEX_WIDTH     (TEX_WIDTH),
      .TEX_HEIGHT    (TEX_HEIGHT)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule
`default_nettype wire

### rtl/core/tfdt_ram.sv
`default_nettype none
module tfdt_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

### rtl/core/tfdt_div.sv
`default_nettype none
module tfdt_div (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [tfdt_pkg::NUM_W-1:0]   num,
   input  wire logic [tfdt_pkg::DIV_W-1:0]   den,
   output logic      [tfdt_pkg::QUO_W-1:0]   quo,
   output logic                              done
);

   localparam int CNT_W = $clog2(tfdt_pkg::QUO_W);

   logic [tfdt_pkg::NUM_W-1:0] rem_ff;
   logic [tfdt_pkg::NUM_W-1:0] dsh_ff;
   logic [tfdt_pkg::QUO_W-1:0] quo_ff;
   logic [CNT_W-1:0]           cnt_ff;
   logic                       busy_ff;
   logic                       done_ff;
   logic                       fits;

   assign fits = rem_ff >= dsh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(tfdt_pkg::QUO_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // restoring divide, one quotient bit per cycle
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= num;
         dsh_ff <= tfdt_pkg::NUM_W'(den) << (tfdt_pkg::QUO_W - 1);
         quo_ff <= '0;
      end else if (busy_ff) begin
         if (fits) begin
            rem_ff <= rem_ff - dsh_ff;
         end
         quo_ff <= {quo_ff[tfdt_pkg::QUO_W-2:0], fits};
         dsh_ff <= dsh_ff >> 1;
      end
   end

   assign quo  = quo_ff;
   assign done = done_ff;

endmodule
`default_nettype wire

### rtl/core/tfdt_ctrl.sv
`default_nettype none
module tfdt_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   input  wire tfdt_pkg::stat_type  stat,
   output tfdt_pkg::cmd_type        cmd
);

   tfdt_pkg::ctrl_state_type state_ff, state_in;
   logic [tfdt_pkg::STEP_W-1:0] step_ff, step_in;
   tfdt_pkg::status_type status_ff, status_in;
   logic rsp_valid_ff, rsp_valid_in;

   tfdt_pkg::mul_sel_type m0, m1, m2;
   tfdt_pkg::dp_op_type   div_op;
   tfdt_pkg::ctrl_state_type div_state;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tfdt_pkg::S_IDLE;
         step_ff      <= '0;
         status_ff    <= tfdt_pkg::ST_DONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // operand sets for the three-term weighted sums
   always_comb begin
      m0 = tfdt_pkg::MUL_AZ_NU;
      m1 = tfdt_pkg::MUL_BZ_NV;
      m2 = tfdt_pkg::MUL_CZ_NW;
      div_op = tfdt_pkg::OP_DIV_Z;
      div_state = tfdt_pkg::S_ZDIV;
      case (state_ff)
         tfdt_pkg::S_UMAC: begin
            m0 = tfdt_pkg::MUL_AU_NU;
            m1 = tfdt_pkg::MUL_BU_NV;
            m2 = tfdt_pkg::MUL_CU_NW;
            div_op = tfdt_pkg::OP_DIV_U;
            div_state = tfdt_pkg::S_UDIV;
         end
         tfdt_pkg::S_VMAC: begin
            m0 = tfdt_pkg::MUL_AV_NU;
            m1 = tfdt_pkg::MUL_BV_NV;
            m2 = tfdt_pkg::MUL_CV_NW;
            div_op = tfdt_pkg::OP_DIV_V;
            div_state = tfdt_pkg::S_VDIV;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      status_in = status_ff;
      rsp_valid_in = rsp_valid_ff;
      req_tready = 1'b0;
      cmd.op = tfdt_pkg::OP_NONE;
      cmd.mul = tfdt_pkg::MUL_NONE;
      cmd.acc = tfdt_pkg::ACC_HOLD;
      cmd.status = status_ff;

      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         tfdt_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op = tfdt_pkg::OP_TAKE;
               state_in = tfdt_pkg::S_DISPATCH;
            end
         end
         tfdt_pkg::S_DISPATCH: begin
            status_in = tfdt_pkg::ST_DONE;
            state_in = tfdt_pkg::S_FIN;
            case (stat.req)
               tfdt_pkg::REQ_LOAD:  cmd.op = tfdt_pkg::OP_LOAD_TEX;
               tfdt_pkg::REQ_CLEAR: cmd.op = tfdt_pkg::OP_CLEAR_DEPTH;
               tfdt_pkg::REQ_TEST:  state_in = tfdt_pkg::S_BOX;
               default: begin
               end
            endcase
         end
         tfdt_pkg::S_BOX: begin
            cmd.op = tfdt_pkg::OP_BOX;
            step_in = '0;
            if (stat.box_out) begin
               status_in = tfdt_pkg::ST_OUT_BOX;
               state_in = tfdt_pkg::S_FIN;
            end else begin
               state_in = tfdt_pkg::S_GEO;
            end
         end
         tfdt_pkg::S_GEO: begin
            step_in = step_ff + 1'b1;
            case (step_ff)
               3'd0: cmd.mul = tfdt_pkg::MUL_E0X_E1Y;
               3'd1: begin
                  cmd.mul = tfdt_pkg::MUL_E0Y_E1X_N;
                  cmd.acc = tfdt_pkg::ACC_LOAD;
               end
               3'd2: begin
                  cmd.mul = tfdt_pkg::MUL_DX_E1Y;
                  cmd.acc = tfdt_pkg::ACC_ADD;
               end
               3'd3: begin
                  cmd.mul = tfdt_pkg::MUL_DY_E1X_N;
                  cmd.acc = tfdt_pkg::ACC_LOAD;
                  cmd.op = tfdt_pkg::OP_CAP_DEN;
               end
               3'd4: begin
                  cmd.mul = tfdt_pkg::MUL_E0X_DY;
                  cmd.acc = tfdt_pkg::ACC_ADD;
               end
               3'd5: begin
                  cmd.mul = tfdt_pkg::MUL_E0Y_DX_N;
                  cmd.acc = tfdt_pkg::ACC_LOAD;
                  cmd.op = tfdt_pkg::OP_CAP_NV;
               end
               3'd6: cmd.acc = tfdt_pkg::ACC_ADD;
               default: begin
                  cmd.op = tfdt_pkg::OP_CAP_NW;
                  step_in = '0;
                  state_in = tfdt_pkg::S_SIGNFIX;
               end
            endcase
         end
         tfdt_pkg::S_SIGNFIX: begin
            cmd.op = tfdt_pkg::OP_SIGN_FIX;
            state_in = tfdt_pkg::S_NU;
         end
         tfdt_pkg::S_NU: begin
            cmd.op = tfdt_pkg::OP_NU;
            state_in = tfdt_pkg::S_TRI;
         end
         tfdt_pkg::S_TRI: begin
            step_in = '0;
            if (stat.tri_out) begin
               status_in = tfdt_pkg::ST_OUT_TRI;
               state_in = tfdt_pkg::S_FIN;
            end else begin
               state_in = tfdt_pkg::S_ZMAC;
            end
         end
         tfdt_pkg::S_ZMAC, tfdt_pkg::S_UMAC, tfdt_pkg::S_VMAC: begin
            step_in = step_ff + 1'b1;
            case (step_ff)
               3'd0: cmd.mul = m0;
               3'd1: begin
                  cmd.mul = m1;
                  cmd.acc = tfdt_pkg::ACC_LOAD;
               end
               3'd2: begin
                  cmd.mul = m2;
                  cmd.acc = tfdt_pkg::ACC_ADD;
               end
               3'd3: cmd.acc = tfdt_pkg::ACC_ADD;
               default: begin
                  cmd.op = div_op;
                  step_in = '0;
                  state_in = div_state;
               end
            endcase
         end
         tfdt_pkg::S_ZDIV: begin
            if (stat.div_done) begin
               cmd.op = tfdt_pkg::OP_CAP_Z;
               state_in = tfdt_pkg::S_DRD;
            end
         end
         tfdt_pkg::S_DRD: begin
            cmd.op = tfdt_pkg::OP_DEPTH_RD;
            state_in = tfdt_pkg::S_DCMP;
         end
         tfdt_pkg::S_DCMP: begin
            if (stat.occluded) begin
               status_in = tfdt_pkg::ST_OCCLUDED;
               state_in = tfdt_pkg::S_FIN;
            end else begin
               cmd.op = tfdt_pkg::OP_DEPTH_WR;
               step_in = '0;
               state_in = tfdt_pkg::S_UMAC;
            end
         end
         tfdt_pkg::S_UDIV: begin
            if (stat.div_done) begin
               cmd.op = tfdt_pkg::OP_CAP_U;
               step_in = '0;
               state_in = tfdt_pkg::S_VMAC;
            end
         end
         tfdt_pkg::S_VDIV: begin
            if (stat.div_done) begin
               cmd.op = tfdt_pkg::OP_CAP_V;
               state_in = tfdt_pkg::S_TRD;
            end
         end
         tfdt_pkg::S_TRD: begin
            cmd.op = tfdt_pkg::OP_TEX_RD;
            status_in = tfdt_pkg::ST_WRITTEN;
            state_in = tfdt_pkg::S_FIN;
         end
         tfdt_pkg::S_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.op = tfdt_pkg::OP_OUT;
               rsp_valid_in = 1'b1;
               state_in = tfdt_pkg::S_IDLE;
            end
         end
         default: state_in = tfdt_pkg::S_IDLE;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule
`default_nettype wire

### rtl/core/tfdt_datapath.sv
`default_nettype none
module tfdt_datapath #(
   parameter int SCREEN_WIDTH = tfdt_pkg::SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = tfdt_pkg::SCREEN_HEIGHT_DEF,
   parameter int TEX_WIDTH = tfdt_pkg::TEX_WIDTH_DEF,
   parameter int TEX_HEIGHT = tfdt_pkg::TEX_HEIGHT_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_wr_en,
   input  wire logic [tfdt_pkg::CFG_IDX_W-1:0]    csr_index,
   input  wire logic [tfdt_pkg::CFG_W-1:0]        csr_wdata,
   input  wire logic [tfdt_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  wire logic [1:0]                        req_tuser,
   input  wire tfdt_pkg::cmd_type                 cmd,
   output tfdt_pkg::stat_type                     stat,
   output logic      [tfdt_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic      [2:0]                        rsp_tuser
);

   localparam int DEPTH_N = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int TEX_N = TEX_WIDTH * TEX_HEIGHT;
   localparam int DADDR_W = $clog2(DEPTH_N);
   localparam int TADDR_W = $clog2(TEX_N);
   localparam int TU_W = $clog2(TEX_WIDTH);
   localparam int TV_W = $clog2(TEX_HEIGHT);
   localparam logic signed [17:0] WMAX = 18'((SCREEN_WIDTH - 1) * 16);
   localparam logic signed [17:0] HMAX = 18'((SCREEN_HEIGHT - 1) * 16);

   logic [47:0] va_pos_ff, vb_pos_ff, vc_pos_ff;
   logic [31:0] va_uv_ff, vb_uv_ff, vc_uv_ff;

   logic [1:0]  req_type_ff;
   logic [8:0]  px_ff;
   logic [7:0]  py_ff;
   logic [7:0]  tu_in_ff, tv_in_ff;
   logic [23:0] col_ff;

   logic signed [17:0] ax, ay, bx, by, cx, cy;
   logic signed [17:0] mnx, mxx, mny, mxy, minx, maxx, miny, maxy;
   logic signed [17:0] pxs, pys, qx, qy;
   logic box_full, box_in;

   logic signed [17:0] e0x_ff, e0y_ff, e1x_ff, e1y_ff, dx_ff, dy_ff;
   logic signed [tfdt_pkg::A_W-1:0]    a_op;
   logic signed [tfdt_pkg::B_W-1:0]    b_op;
   logic signed [tfdt_pkg::PROD_W-1:0] prod_ff;
   logic signed [tfdt_pkg::ACC_W-1:0]  acc_ff;
   logic signed [tfdt_pkg::B_W-1:0]    den_ff, nv_ff, nw_ff, nu_ff;

   logic signed [15:0]      z_ff;
   logic [TU_W-1:0]         tu_ff;
   logic [TV_W-1:0]         tv_ff;

   logic                         div_start;
   logic [tfdt_pkg::NUM_W-1:0]   div_num;
   logic [tfdt_pkg::DIV_W-1:0]   div_den;
   logic [tfdt_pkg::QUO_W-1:0]   div_quo;
   logic                         div_done;
   logic signed [tfdt_pkg::NUM_W-1:0] z_num;

   logic [DADDR_W-1:0] depth_idx;
   logic               clear_ok, depth_wr;
   logic [15:0]        depth_wdata, depth_rd;
   logic [TADDR_W-1:0] load_addr, read_addr, tex_addr;
   logic               load_ok, tex_wr;
   logic [23:0]        tex_rd;

   logic [2:0]  out_status_ff;
   logic [8:0]  out_x_ff;
   logic [7:0]  out_y_ff;
   logic [23:0] out_color_ff;
   logic [15:0] out_depth_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_pos_ff <= '0;
         vb_pos_ff <= '0;
         vc_pos_ff <= '0;
         va_uv_ff  <= '0;
         vb_uv_ff  <= '0;
         vc_uv_ff  <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            tfdt_pkg::CFG_VA_POS: va_pos_ff <= csr_wdata;
            tfdt_pkg::CFG_VB_POS: vb_pos_ff <= csr_wdata;
            tfdt_pkg::CFG_VC_POS: vc_pos_ff <= csr_wdata;
            tfdt_pkg::CFG_VA_UV:  va_uv_ff  <= csr_wdata[31:0];
            tfdt_pkg::CFG_VB_UV:  vb_uv_ff  <= csr_wdata[31:0];
            tfdt_pkg::CFG_VC_UV:  vc_uv_ff  <= csr_wdata[31:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == tfdt_pkg::OP_TAKE) begin
         req_type_ff <= req_tuser;
         px_ff       <= req_tdata[8:0];
         py_ff       <= req_tdata[16:9];
         tu_in_ff    <= req_tdata[24:17];
         tv_in_ff    <= req_tdata[32:25];
         col_ff      <= req_tdata[56:33];
      end
   end

   // bounding box
   assign ax = 18'($signed(va_pos_ff[15:0]));
   assign ay = 18'($signed(va_pos_ff[31:16]));
   assign bx = 18'($signed(vb_pos_ff[15:0]));
   assign by = 18'($signed(vb_pos_ff[31:16]));
   assign cx = 18'($signed(vc_pos_ff[15:0]));
   assign cy = 18'($signed(vc_pos_ff[31:16]));

   always_comb begin
      mnx = (ax < bx) ? ax : bx;
      mnx = (mnx < cx) ? mnx : cx;
      mxx = (ax > bx) ? ax : bx;
      mxx = (mxx > cx) ? mxx : cx;
      mny = (ay < by) ? ay : by;
      mny = (mny < cy) ? mny : cy;
      mxy = (ay > by) ? ay : by;
      mxy = (mxy > cy) ? mxy : cy;
      minx = (mnx < 0) ? 18'sd0 : ((mnx > WMAX) ? WMAX : mnx);
      maxx = (mxx < 0) ? 18'sd0 : ((mxx > WMAX) ? WMAX : mxx);
      miny = (mny < 0) ? 18'sd0 : ((mny > HMAX) ? HMAX : mny);
      maxy = (mxy < 0) ? 18'sd0 : ((mxy > HMAX) ? HMAX : mxy);
   end

   assign pxs = $signed({9'b0, px_ff});
   assign pys = $signed({10'b0, py_ff});
   assign qx  = $signed({5'b0, px_ff, 4'b0});
   assign qy  = $signed({6'b0, py_ff, 4'b0});

   assign box_full = (minx == 18'sd0 && maxx == WMAX) || (miny == 18'sd0 && maxy == HMAX);
   assign box_in = (pxs >= (minx >>> 4)) && (qx < maxx)
                && (pys >= (miny >>> 4)) && (qy < maxy);

   always_ff @(posedge clock) begin
      if (cmd.op == tfdt_pkg::OP_BOX) begin
         e0x_ff <= bx - ax;
         e0y_ff <= by - ay;
         e1x_ff <= cx - ax;
         e1y_ff <= cy - ay;
         dx_ff  <= qx - ax;
         dy_ff  <= qy - ay;
      end
   end

   // shared multiplier and accumulator
   always_comb begin
      a_op = '0;
      b_op = '0;
      case (cmd.mul)
         tfdt_pkg::MUL_E0X_E1Y: begin
            a_op = e0x_ff;
            b_op = tfdt_pkg::B_W'(e1y_ff);
         end
         tfdt_pkg::MUL_E0Y_E1X_N: begin
            a_op = -e0y_ff;
            b_op = tfdt_pkg::B_W'(e1x_ff);
         end
         tfdt_pkg::MUL_DX_E1Y: begin
            a_op = dx_ff;
            b_op = tfdt_pkg::B_W'(e1y_ff);
         end
         tfdt_pkg::MUL_DY_E1X_N: begin
            a_op = -dy_ff;
            b_op = tfdt_pkg::B_W'(e1x_ff);
         end
         tfdt_pkg::MUL_E0X_DY: begin
            a_op = e0x_ff;
            b_op = tfdt_pkg::B_W'(dy_ff);
         end
         tfdt_pkg::MUL_E0Y_DX_N: begin
            a_op = -e0y_ff;
            b_op = tfdt_pkg::B_W'(dx_ff);
         end
         tfdt_pkg::MUL_AZ_NU: begin
            a_op = 18'($signed(va_pos_ff[47:32]));
            b_op = nu_ff;
         end
         tfdt_pkg::MUL_BZ_NV: begin
            a_op = 18'($signed(vb_pos_ff[47:32]));
            b_op = nv_ff;
         end
         tfdt_pkg::MUL_CZ_NW: begin
            a_op = 18'($signed(vc_pos_ff[47:32]));
            b_op = nw_ff;
         end
         tfdt_pkg::MUL_AU_NU: begin
            a_op = $signed({2'b0, va_uv_ff[15:0]});
            b_op = nu_ff;
         end
         tfdt_pkg::MUL_BU_NV: begin
            a_op = $signed({2'b0, vb_uv_ff[15:0]});
            b_op = nv_ff;
         end
         tfdt_pkg::MUL_CU_NW: begin
            a_op = $signed({2'b0, vc_uv_ff[15:0]});
            b_op = nw_ff;
         end
         tfdt_pkg::MUL_AV_NU: begin
            a_op = $signed({2'b0, va_uv_ff[31:16]});
            b_op = nu_ff;
         end
         tfdt_pkg::MUL_BV_NV: begin
            a_op = $signed({2'b0, vb_uv_ff[31:16]});
            b_op = nv_ff;
         end
         tfdt_pkg::MUL_CV_NW: begin
            a_op = $signed({2'b0, vc_uv_ff[31:16]});
            b_op = nw_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= a_op * b_op;
      case (cmd.acc)
         tfdt_pkg::ACC_LOAD: acc_ff <= tfdt_pkg::ACC_W'(prod_ff);
         tfdt_pkg::ACC_ADD:  acc_ff <= acc_ff + tfdt_pkg::ACC_W'(prod_ff);
         default: begin
         end
      endcase
   end

   // edge weights, made positive-area
   always_ff @(posedge clock) begin
      case (cmd.op)
         tfdt_pkg::OP_CAP_DEN: den_ff <= acc_ff[tfdt_pkg::B_W-1:0];
         tfdt_pkg::OP_CAP_NV:  nv_ff  <= acc_ff[tfdt_pkg::B_W-1:0];
         tfdt_pkg::OP_CAP_NW:  nw_ff  <= acc_ff[tfdt_pkg::B_W-1:0];
         tfdt_pkg::OP_SIGN_FIX: begin
            if (den_ff < 0) begin
               den_ff <= -den_ff;
               nv_ff  <= -nv_ff;
               nw_ff  <= -nw_ff;
            end
         end
         tfdt_pkg::OP_NU: nu_ff <= den_ff - nv_ff - nw_ff;
         default: begin
         end
      endcase
   end

   // depth numerator biased by half a range so the quotient stays unsigned
   assign z_num = (acc_ff <<< 1) + tfdt_pkg::NUM_W'(den_ff)
                + (tfdt_pkg::NUM_W'(den_ff) <<< 16);

   assign div_start = (cmd.op == tfdt_pkg::OP_DIV_Z) || (cmd.op == tfdt_pkg::OP_DIV_U)
                   || (cmd.op == tfdt_pkg::OP_DIV_V);

   always_comb begin
      if (cmd.op == tfdt_pkg::OP_DIV_Z) begin
         div_num = z_num;
         div_den = tfdt_pkg::DIV_W'(den_ff) << 1;
      end else begin
         div_num = acc_ff;
         div_den = tfdt_pkg::DIV_W'(den_ff) << 7;
      end
   end

   tfdt_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .quo   (div_quo),
      .done  (div_done)
   );

   always_ff @(posedge clock) begin
      case (cmd.op)
         tfdt_pkg::OP_CAP_Z: z_ff <= $signed({~div_quo[15], div_quo[14:0]});
         tfdt_pkg::OP_CAP_U: begin
            if (div_quo > tfdt_pkg::QUO_W'(TEX_WIDTH - 1)) begin
               tu_ff <= TU_W'(TEX_WIDTH - 1);
            end else begin
               tu_ff <= div_quo[TU_W-1:0];
            end
         end
         tfdt_pkg::OP_CAP_V: begin
            if (div_quo > tfdt_pkg::QUO_W'(TEX_HEIGHT - 1)) begin
               tv_ff <= TV_W'(TEX_HEIGHT - 1);
            end else begin
               tv_ff <= div_quo[TV_W-1:0];
            end
         end
         default: begin
         end
      endcase
   end

   // depth store
   assign depth_idx = DADDR_W'(int'(py_ff) * SCREEN_WIDTH + int'(px_ff));
   assign clear_ok = (int'(px_ff) < SCREEN_WIDTH) && (int'(py_ff) < SCREEN_HEIGHT);
   assign depth_wr = ((cmd.op == tfdt_pkg::OP_CLEAR_DEPTH) && clear_ok)
                  || (cmd.op == tfdt_pkg::OP_DEPTH_WR);
   assign depth_wdata = (cmd.op == tfdt_pkg::OP_CLEAR_DEPTH) ? tfdt_pkg::DEPTH_FAR : z_ff;

   tfdt_ram #(
      .WIDTH (16),
      .DEPTH (DEPTH_N)
   ) u_depth_ram (
      .clock   (clock),
      .wr_en   (depth_wr),
      .addr    (depth_idx),
      .wr_data (depth_wdata),
      .rd_en   (cmd.op == tfdt_pkg::OP_DEPTH_RD),
      .rd_data (depth_rd)
   );

   // texel store
   assign load_ok = (int'(tu_in_ff) < TEX_WIDTH) && (int'(tv_in_ff) < TEX_HEIGHT);
   assign load_addr = TADDR_W'(int'(tv_in_ff) * TEX_WIDTH + int'(tu_in_ff));
   assign read_addr = TADDR_W'(int'(tv_ff) * TEX_WIDTH + int'(tu_ff));
   assign tex_wr = (cmd.op == tfdt_pkg::OP_LOAD_TEX) && load_ok;
   assign tex_addr = (cmd.op == tfdt_pkg::OP_LOAD_TEX) ? load_addr : read_addr;

   tfdt_ram #(
      .WIDTH (24),
      .DEPTH (TEX_N)
   ) u_texel_ram (
      .clock   (clock),
      .wr_en   (tex_wr),
      .addr    (tex_addr),
      .wr_data (col_ff),
      .rd_en   (cmd.op == tfdt_pkg::OP_TEX_RD),
      .rd_data (tex_rd)
   );

   // result register
   always_ff @(posedge clock) begin
      if (cmd.op == tfdt_pkg::OP_OUT) begin
         out_status_ff <= cmd.status;
         if (req_type_ff == tfdt_pkg::REQ_CLEAR || req_type_ff == tfdt_pkg::REQ_TEST) begin
            out_x_ff <= px_ff;
            out_y_ff <= py_ff;
         end else begin
            out_x_ff <= '0;
            out_y_ff <= '0;
         end
         out_color_ff <= (cmd.status == tfdt_pkg::ST_WRITTEN) ? tex_rd : 24'd0;
         if (cmd.status == tfdt_pkg::ST_WRITTEN || cmd.status == tfdt_pkg::ST_OCCLUDED) begin
            out_depth_ff <= z_ff;
         end else begin
            out_depth_ff <= '0;
         end
      end
   end

   assign stat.req = req_type_ff;
   assign stat.box_out = box_full || !box_in;
   assign stat.tri_out = (den_ff == 0) || (nu_ff < 0) || (nv_ff < 0) || (nw_ff < 0);
   assign stat.div_done = div_done;
   assign stat.occluded = z_ff > $signed(depth_rd);

   assign rsp_tdata = {7'b0, out_depth_ff, out_color_ff, out_y_ff, out_x_ff};
   assign rsp_tuser = out_status_ff;

endmodule
`default_nettype wire

### rtl/core/tfdt_checker.sv
`default_nettype none
`include "assert_macros.svh"
module tfdt_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_tvalid,
   input wire logic                            req_tready,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [tfdt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input wire logic [2:0]                      rsp_tuser
);

   `TFDT_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid, "result beat dropped while stalled")
   `TFDT_ASSERT(a_one_at_a_time, clock, reset, req_tvalid && req_tready |=> !req_tready, "second beat taken while busy")
   `TFDT_ASSERT(a_color_only_written, clock, reset, rsp_tvalid && rsp_tuser != tfdt_pkg::ST_WRITTEN |-> rsp_tdata[40:17] == 24'd0, "color on a beat that wrote nothing")
   `TFDT_ASSERT(a_depth_only_tested, clock, reset, rsp_tvalid && (rsp_tuser == tfdt_pkg::ST_OUT_BOX || rsp_tuser == tfdt_pkg::ST_OUT_TRI) |-> rsp_tdata[56:41] == 16'd0, "depth on a rejected fragment")

endmodule

bind triangle_fragment_depth_texture tfdt_checker u_checker (.*);
`default_nettype wire

### sim/tb_triangle_fragment_depth_texture.sv
`default_nettype none
module tb_triangle_fragment_depth_texture;

   localparam int SW = 320;
   localparam int SH = 240;
   localparam int TW = 256;
   localparam int TH = 256;
   localparam longint CYCLE_LIMIT = 3000000;

   typedef struct packed {
      tfdt_pkg::status_type status;
      logic [8:0]        x;
      logic [7:0]        y;
      logic [23:0]       color;
      logic signed [15:0] depth;
   } frag_result_type;

   typedef struct packed {
      tfdt_pkg::req_kind_type kind;
      logic [63:0]  data;
   } req_beat_type;

   logic clock, reset;
   logic csr_wr_en;
   logic [tfdt_pkg::CFG_IDX_W-1:0] csr_index;
   logic [tfdt_pkg::CFG_W-1:0] csr_wdata;
   logic req_tvalid, req_tready;
   logic [tfdt_pkg::REQ_DATA_W-1:0] req_tdata;
   logic [1:0] req_tuser;
   logic rsp_tvalid, rsp_tready;
   logic [tfdt_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [2:0] rsp_tuser;

   triangle_fragment_depth_texture dut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   // shadow of the vertex registers and the two stores
   logic [47:0] vtx_pos [3];
   logic [31:0] vtx_uv [3];
   logic signed [15:0] zbuf [SW*SH];
   bit zbuf_valid [SW*SH];
   logic [23:0] texmem [TW*TH];
   bit texmem_valid [TW*TH];

   req_beat_type pending_beats [$];
   frag_result_type expected_results [$];
   int errors = 0;
   longint cycles = 0;
   int results_seen = 0;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_triangle_fragment_depth_texture: errors");
         $finish;
      end
   end

   function automatic longint coord(input int k, input int sh);
      logic [15:0] f;
      f = 16'(vtx_pos[k] >> sh);
      return longint'($signed(f));
   endfunction

   // box and triangle test plus interpolated depth and texel address
   function automatic void rasterize(input int px, input int py,
                                     output tfdt_pkg::status_type st,
                                     output logic signed [15:0] z, output int tu,
                                     output int tv);
      longint ax, ay, az, bx, by, bz, cx, cy, cz, wmax, hmax, minx, maxx, miny, maxy;
      longint qx, qy, e0x, e0y, e1x, e1y, dx, dy, den, nv, nw, nu, num, n2, d2, q, uu, vv;
      ax = coord(0, 0); ay = coord(0, 16); az = coord(0, 32);
      bx = coord(1, 0); by = coord(1, 16); bz = coord(1, 32);
      cx = coord(2, 0); cy = coord(2, 16); cz = coord(2, 32);
      wmax = longint'((SW - 1) * 16); hmax = longint'((SH - 1) * 16);
      minx = ax < bx ? ax : bx; minx = minx < cx ? minx : cx;
      maxx = ax > bx ? ax : bx; maxx = maxx > cx ? maxx : cx;
      miny = ay < by ? ay : by; miny = miny < cy ? miny : cy;
      maxy = ay > by ? ay : by; maxy = maxy > cy ? maxy : cy;
      minx = minx < 0 ? 0 : (minx > wmax ? wmax : minx);
      maxx = maxx < 0 ? 0 : (maxx > wmax ? wmax : maxx);
      miny = miny < 0 ? 0 : (miny > hmax ? hmax : miny);
      maxy = maxy < 0 ? 0 : (maxy > hmax ? hmax : maxy);
      qx = longint'(px) * 16; qy = longint'(py) * 16;
      st = tfdt_pkg::ST_OUT_BOX; z = '0; tu = 0; tv = 0;
      if ((minx == 0 && maxx == wmax) || (miny == 0 && maxy == hmax)) return;
      if (px < (minx >>> 4) || qx >= maxx || py < (miny >>> 4) || qy >= maxy) return;
      e0x = bx - ax; e0y = by - ay; e1x = cx - ax; e1y = cy - ay;
      dx = qx - ax; dy = qy - ay;
      den = e0x * e1y - e0y * e1x;
      nv = dx * e1y - dy * e1x;
      nw = e0x * dy - e0y * dx;
      if (den < 0) begin
         den = -den; nv = -nv; nw = -nw;
      end
      nu = den - nv - nw;
      st = tfdt_pkg::ST_OUT_TRI;
      if (den == 0 || nu < 0 || nv < 0 || nw < 0) return;
      num = az * nu + bz * nv + cz * nw;
      n2 = 2 * num + den; d2 = 2 * den;
      q = n2 / d2;
      if (n2 % d2 != 0 && n2 < 0) q = q - 1;
      z = q[15:0];
      st = tfdt_pkg::ST_OCCLUDED;
      uu = (longint'(vtx_uv[0][15:0]) * nu + longint'(vtx_uv[1][15:0]) * nv
            + longint'(vtx_uv[2][15:0]) * nw) / (den * 128);
      vv = (longint'(vtx_uv[0][31:16]) * nu + longint'(vtx_uv[1][31:16]) * nv
            + longint'(vtx_uv[2][31:16]) * nw) / (den * 128);
      tu = uu > TW - 1 ? TW - 1 : int'(uu);
      tv = vv > TH - 1 ? TH - 1 : int'(vv);
   endfunction

   // queue one beat and work out what it returns
   task automatic put_item(input tfdt_pkg::req_kind_type kind, input int px, input int py,
                           input int u, input int v, input int col);
      req_beat_type b;
      frag_result_type r;
      tfdt_pkg::status_type st;
      logic signed [15:0] z;
      int tu, tv, idx;
      b.kind = kind;
      b.data = '0;
      b.data[8:0] = 9'(px); b.data[16:9] = 8'(py); b.data[24:17] = 8'(u);
      b.data[32:25] = 8'(v);
      b.data[56:33] = 24'(col);
      r = '0;
      r.status = tfdt_pkg::ST_DONE;
      case (kind)
         tfdt_pkg::REQ_LOAD: begin
            texmem[v*TW+u] = 24'(col);
            texmem_valid[v*TW+u] = 1;
         end
         tfdt_pkg::REQ_CLEAR: begin
            r.x = 9'(px); r.y = 8'(py);
            if (px < SW && py < SH) begin
               zbuf[py*SW+px] = tfdt_pkg::DEPTH_FAR;
               zbuf_valid[py*SW+px] = 1;
            end
         end
         tfdt_pkg::REQ_TEST: begin
            r.x = 9'(px); r.y = 8'(py);
            rasterize(px, py, st, z, tu, tv);
            r.status = st;
            if (st == tfdt_pkg::ST_OCCLUDED) begin
               r.depth = z;
               idx = py * SW + px;
               if (z <= zbuf[idx]) begin
                  zbuf[idx] = z;
                  r.color = texmem[tv*TW+tu];
                  r.status = tfdt_pkg::ST_WRITTEN;
               end
            end
         end
         default: ;
      endcase
      pending_beats.push_back(b);
      expected_results.push_back(r);
   endtask

   // a fragment test preceded by whatever clear or load keeps every read defined
   task automatic issue_test(input int px, input int py);
      tfdt_pkg::status_type st;
      logic signed [15:0] z;
      int tu, tv, idx;
      rasterize(px, py, st, z, tu, tv);
      if (st == tfdt_pkg::ST_OCCLUDED) begin
         idx = py * SW + px;
         if (!zbuf_valid[idx])
            put_item(tfdt_pkg::REQ_CLEAR, px, py, $urandom, $urandom, $urandom);
         if (z <= zbuf[idx] && !texmem_valid[tv*TW+tu])
            put_item(tfdt_pkg::REQ_LOAD, $urandom, $urandom, tu, tv, $urandom);
      end
      put_item(tfdt_pkg::REQ_TEST, px, py, $urandom, $urandom, $urandom);
   endtask

   task automatic write_reg(input tfdt_pkg::cfg_index_type i, input logic [47:0] val);
      @(posedge clock);
      csr_wr_en <= 1;
      csr_index <= i;
      csr_wdata <= val;
      if (i < tfdt_pkg::CFG_VA_UV) vtx_pos[i] = val;
      else vtx_uv[i-3] = val[31:0];
   endtask

   task automatic drain();
      wait (pending_beats.size() == 0 && expected_results.size() == 0);
      repeat (120) @(posedge clock);
   endtask

   function automatic logic [47:0] rand_vertex(input int span);
      int x, y;
      x = $urandom_range(0, span * 16) - 100;
      y = $urandom_range(0, (span * 3 / 4) * 16) - 80;
      return {16'($urandom), 16'(y), 16'(x)};
   endfunction

   task automatic configure(input logic [47:0] a, input logic [47:0] b,
                            input logic [47:0] c, input logic [31:0] ua,
                            input logic [31:0] ub, input logic [31:0] uc);
      write_reg(tfdt_pkg::CFG_VA_POS, a);
      write_reg(tfdt_pkg::CFG_VB_POS, b);
      write_reg(tfdt_pkg::CFG_VC_POS, c);
      write_reg(tfdt_pkg::CFG_VA_UV, {16'b0, ua});
      write_reg(tfdt_pkg::CFG_VB_UV, {16'b0, ub});
      write_reg(tfdt_pkg::CFG_VC_UV, {16'b0, uc});
      @(posedge clock);
      csr_wr_en <= 0;
   endtask

   // random fragments near the triangle and anywhere on the grid, plus loads, clears and odd beats
   task automatic random_phase(input int n);
      int lox, hix, loy, hiy, k, sel, vx, vy;
      lox = 319; hix = 0; loy = 239; hiy = 0;
      for (k = 0; k < 3; k++) begin
         vx = int'(coord(k, 0) / 16);
         vy = int'(coord(k, 16) / 16);
         lox = vx < lox ? vx : lox;
         hix = vx > hix ? vx : hix;
         loy = vy < loy ? vy : loy;
         hiy = vy > hiy ? vy : hiy;
      end
      lox = lox < 0 ? 0 : lox; hix = hix > 319 ? 319 : hix;
      loy = loy < 0 ? 0 : loy; hiy = hiy > 239 ? 239 : hiy;
      if (hix < lox) hix = lox;
      if (hiy < loy) hiy = loy;
      for (k = 0; k < n; k++) begin
         sel = $urandom_range(0, 99);
         if (sel < 60)
            issue_test($urandom_range(lox, hix), $urandom_range(loy, hiy));
         else if (sel < 68)
            issue_test($urandom_range(0, 511), $urandom_range(0, 255));
         else if (sel < 82)
            put_item(tfdt_pkg::REQ_LOAD, $urandom, $urandom, $urandom_range(0, 255),
                     $urandom_range(0, 255), $urandom);
         else if (sel < 95)
            put_item(tfdt_pkg::REQ_CLEAR, $urandom_range(lox, hix), $urandom_range(loy, hiy),
                     $urandom, $urandom, $urandom);
         else if (sel < 98)
            put_item(tfdt_pkg::REQ_CLEAR, $urandom_range(0, 511), $urandom_range(0, 255),
                     $urandom, $urandom, $urandom);
         else
            put_item(tfdt_pkg::REQ_NONE, $urandom, $urandom, $urandom, $urandom, $urandom);
      end
   endtask

   // sender: bursts with gaps
   int burst_left = 0, gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 0;
         req_tdata <= '0;
         req_tuser <= tfdt_pkg::REQ_NONE;
      end else if (!(req_tvalid && !req_tready)) begin
         if (req_tvalid && req_tready) void'(pending_beats.pop_front());
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_tvalid <= 0;
         end else if (pending_beats.size() > 0) begin
            req_tvalid <= 1;
            req_tdata <= pending_beats[0].data;
            req_tuser <= pending_beats[0].kind;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 40);
               gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 12);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_tvalid <= 0;
         end
      end
   end

   // receiver: random stall pattern and one long hold-off
   int hold_left = 0;
   int stall_mode = 0;
   bit long_hold_done = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 0;
      end else if (!long_hold_done && results_seen >= 300) begin
         long_hold_done <= 1;
         hold_left <= 600;
         rsp_tready <= 0;
      end else begin
         if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
         case (stall_mode)
            0: rsp_tready <= 1;
            1: rsp_tready <= $urandom_range(0, 3) != 0;
            default: rsp_tready <= $urandom_range(0, 3) == 0;
         endcase
      end
   end

   // monitor: compare each beat with the oldest expectation
   always @(posedge clock) begin
      frag_result_type want, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen <= results_seen + 1;
         got.status = tfdt_pkg::status_type'(rsp_tuser);
         got.x = rsp_tdata[8:0];
         got.y = rsp_tdata[16:9];
         got.color = rsp_tdata[40:17];
         got.depth = rsp_tdata[56:41];
         if (expected_results.size() == 0) begin
            $display("%0t unexpected beat: status %0d x %0d y %0d", $time, got.status,
                     got.x, got.y);
            errors <= errors + 1;
         end else begin
            want = expected_results.pop_front();
            if (got !== want || rsp_tdata[63:57] !== '0) begin
               $display("%0t mismatch: expected st %0d x %0d y %0d col %h z %0d", $time,
                        want.status, want.x, want.y, want.color, want.depth);
               $display("%0t            actual st %0d x %0d y %0d col %h z %0d", $time,
                        got.status, got.x, got.y, got.color, got.depth);
               errors <= errors + 1;
            end
         end
      end
   end

   initial begin
      int p, k;
      reset = 1;
      csr_wr_en = 0;
      csr_index = '0;
      csr_wdata = '0;
      for (k = 0; k < 3; k++) begin
         vtx_pos[k] = '0;
         vtx_uv[k] = '0;
      end
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: a plain triangle, clockwise order, degenerate, full span and extremes
      configure({16'sh0100, 16'(20*16+8), 16'(10*16+3)},
                {16'sh2000, 16'(30*16), 16'(60*16+12)},
                {16'shc000, 16'(80*16+5), 16'(25*16)},
                32'h0000_0000, {16'hffff, 16'h0000}, {16'h0000, 16'hffff});
      put_item(tfdt_pkg::REQ_LOAD, 0, 0, 0, 0, 0);
      put_item(tfdt_pkg::REQ_LOAD, 0, 0, 255, 255, 'hffffff);
      put_item(tfdt_pkg::REQ_CLEAR, 511, 255, 0, 0, 0);
      put_item(tfdt_pkg::REQ_CLEAR, 319, 239, 0, 0, 0);
      put_item(tfdt_pkg::REQ_NONE, 511, 255, 255, 255, 'hffffff);
      issue_test(0, 0);
      issue_test(511, 255);
      issue_test(30, 30);
      issue_test(30, 30);
      issue_test(25, 40);
      issue_test(10, 20);
      issue_test(60, 30);
      issue_test(80, 25);
      drain();
      configure({16'sh7fff, 16'(200*16), 16'(200*16)},
                {16'sh8000, 16'(120*16), 16'(250*16)},
                {16'sh0000, 16'(100*16), 16'(150*16)},
                32'hffff_ffff, 32'h0000_0000, 32'h1234_8000);
      for (k = 0; k < 6; k++) issue_test($urandom_range(150, 250), $urandom_range(100, 200));
      drain();
      configure({16'h0, 16'(50*16), 16'(50*16)}, {16'h0, 16'(60*16), 16'(60*16)},
                {16'h0, 16'(70*16), 16'(70*16)}, 0, 0, 0);
      issue_test(55, 55);
      issue_test(60, 60);
      drain();
      configure({16'h1234, 16'hffff, 16'h8000}, {16'h0, 16'h7fff, 16'h7fff},
                {16'h0, 16'h0, 16'h0}, 0, 0, 0);
      issue_test(100, 100);
      issue_test(0, 0);
      drain();

      for (p = 0; p < 16; p++) begin
         if (p % 5 == 4)
            configure(rand_vertex(60) + {32'b0, 16'(200*16)}, rand_vertex(60),
                      rand_vertex(60), $urandom, $urandom, $urandom);
         else
            configure(rand_vertex(320), rand_vertex(320), rand_vertex(320),
                      $urandom, $urandom, $urandom);
         random_phase(100);
         drain();
      end

      if (errors == 0) begin
         $display("tb_triangle_fragment_depth_texture: clean");
      end else begin
         $display("tb_triangle_fragment_depth_texture: errors");
      end
      $finish;
   end

endmodule
`default_nettype wire
